// ----- design/vertex_transform_4x4_top_assert.svh -----
// Assertion macros for the vertex transform block.
// Used by vertex_transform_4x4_top; relies on ports named clock and reset.
`ifndef VERTEX_TRANSFORM_4X4_TOP_ASSERT_SVH
`define VERTEX_TRANSFORM_4X4_TOP_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define VTX_ASSERT_NOW(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define VTX_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ----- design/vtx_pkg.sv -----
// Shared types and constants for the vertex transform block.
// No dependencies; imported by every module of the block.
package vtx_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_W    = 32;
   localparam int DIM       = 4;
   localparam int N_ELEM    = DIM * DIM;
   localparam int IDX_W     = 2;
   localparam int ADDR_W    = 4;
   localparam int PROD_W    = 2 * WORD_W;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int SUM_W     = PROD_W + 2;
   localparam int HI_W      = SUM_W - FRAC_BITS - WORD_W + 1;
   localparam int QDEPTH    = 4;
   localparam int QAW       = $clog2(QDEPTH);
   localparam int QCW       = $clog2(QDEPTH + 1);

   localparam logic signed [WORD_W-1:0] FIX_ONE = WORD_W'(1) << FRAC_BITS;
   localparam logic signed [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_XFORM = 1'b1
   } op_type;

   // One queued transaction, already classified
   typedef struct packed {
      op_type                          op;
      logic [ADDR_W-1:0]               addr;
      logic [WORD_W-1:0]               elem;
      logic [DIM-1:0][WORD_W-1:0]      vec;
   } cmd_type;

   // Queue status toward the back end
   typedef struct packed {
      logic            valid;
      logic [QCW-1:0]  fill;
   } qstat_type;

endpackage

// ----- design/vtx_front.sv -----
// Front end: accepts request transactions, classifies them and queues them.
// Depends on vtx_pkg.
module vtx_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_mode,
   input  logic [1:0]                     req_col_index,
   input  logic [1:0]                     req_row_index,
   input  logic signed [31:0]             req_element_value,
   input  logic signed [31:0]             req_vec_x,
   input  logic signed [31:0]             req_vec_y,
   input  logic signed [31:0]             req_vec_z,
   input  logic signed [31:0]             req_vec_w,
   input  logic                           deq,
   output vtx_pkg::cmd_type               head,
   output vtx_pkg::qstat_type             stat
);
   import vtx_pkg::*;

   cmd_type          queue_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   fill_ff, fill_in;
   cmd_type          cmd;
   logic             enq;

   // Classify the incoming transaction
   always_comb begin
      cmd.op   = req_mode ? OP_XFORM : OP_WRITE;
      cmd.addr = {req_col_index, req_row_index};
      cmd.elem = req_element_value;
      cmd.vec  = {req_vec_w, req_vec_z, req_vec_y, req_vec_x};
   end

   assign req_ready = (fill_ff != QCW'(QDEPTH));
   assign enq       = req_valid && req_ready;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = enq ? QAW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = deq ? QAW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = QCW'(fill_ff + QCW'(enq) - QCW'(deq));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the classified transaction
   always_ff @(posedge clock) begin
      if (enq) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign head       = queue_ff[rd_ptr_ff];
   assign stat.valid = (fill_ff != '0);
   assign stat.fill  = fill_ff;

endmodule

// ----- design/vtx_back.sv -----
// Back end: holds the matrix, applies element writes and forms all 16 products.
// Depends on vtx_pkg.
module vtx_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  vtx_pkg::cmd_type                       head,
   input  vtx_pkg::qstat_type                     stat,
   input  logic                                   advance,
   output logic                                   deq,
   output logic                                   prod_valid,
   output logic signed [vtx_pkg::PROD_W-1:0]      prod [vtx_pkg::N_ELEM]
);
   import vtx_pkg::*;

   logic signed [WORD_W-1:0]  matrix_ff [N_ELEM];
   logic signed [PROD_W-1:0]  prod_ff   [N_ELEM];
   logic signed [PROD_W-1:0]  prod_in   [N_ELEM];
   logic                      pv_ff;
   logic                      do_write;

   assign deq      = stat.valid && advance;
   assign do_write = deq && (head.op == OP_WRITE);

   // Hold the matrix; reset to identity, update on element writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N_ELEM; i++) begin
            matrix_ff[i] <= ((i % (DIM + 1)) == 0) ? FIX_ONE : '0;
         end
      end else if (do_write) begin
         matrix_ff[head.addr] <= $signed(head.elem);
      end
   end

   // One multiplier per matrix element; column c scales vector component c
   always_comb begin
      for (int i = 0; i < N_ELEM; i++) begin
         prod_in[i] = $signed(matrix_ff[i]) * $signed(head.vec[i / DIM]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (advance) begin
         pv_ff <= deq && (head.op == OP_XFORM);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = pv_ff;
   assign prod       = prod_ff;

endmodule

// ----- design/vtx_reduce.sv -----
// Reduction: sums products per row over two stages, floor-shifts and saturates.
// Depends on vtx_pkg; drives the response registers.
module vtx_reduce (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   prod_valid,
   input  logic signed [vtx_pkg::PROD_W-1:0]      prod [vtx_pkg::N_ELEM],
   input  logic                                   rsp_ready,
   output logic                                   advance,
   output logic                                   rsp_valid,
   output logic signed [31:0]                     rsp_out_x,
   output logic signed [31:0]                     rsp_out_y,
   output logic signed [31:0]                     rsp_out_z,
   output logic signed [31:0]                     rsp_out_w,
   output logic                                   rsp_clipped
);
   import vtx_pkg::*;

   logic signed [PAIR_W-1:0]  pair_ff [DIM][2];
   logic signed [PAIR_W-1:0]  pair_in [DIM][2];
   logic signed [SUM_W-1:0]   sum_ff  [DIM];
   logic signed [SUM_W-1:0]   sum_in  [DIM];
   logic [WORD_W-1:0]         res_in  [DIM];
   logic [WORD_W-1:0]         res_ff  [DIM];
   logic [HI_W-1:0]           hi_bits [DIM];
   logic                      clip_in;
   logic                      clip_ff;
   logic                      pairv_ff;
   logic                      sumv_ff;
   logic                      rspv_ff;

   // Stall the whole pipe only while a result waits on the output
   assign advance = !rspv_ff || rsp_ready;

   // Add products in pairs, then the two pairs
   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         pair_in[r][0] = PAIR_W'(prod[r]) + PAIR_W'(prod[DIM + r]);
         pair_in[r][1] = PAIR_W'(prod[2*DIM + r]) + PAIR_W'(prod[3*DIM + r]);
         sum_in[r]     = SUM_W'(pair_ff[r][0]) + SUM_W'(pair_ff[r][1]);
      end
   end

   // Floor-shift and saturate each row
   always_comb begin
      clip_in = 1'b0;
      for (int r = 0; r < DIM; r++) begin
         hi_bits[r] = sum_ff[r][SUM_W-1 -: HI_W];
         if (!(&hi_bits[r]) && (|hi_bits[r])) begin
            res_in[r] = sum_ff[r][SUM_W-1] ? SAT_MIN : SAT_MAX;
            clip_in   = 1'b1;
         end else begin
            res_in[r] = sum_ff[r][FRAC_BITS +: WORD_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pairv_ff <= 1'b0;
         sumv_ff  <= 1'b0;
         rspv_ff  <= 1'b0;
      end else if (advance) begin
         pairv_ff <= prod_valid;
         sumv_ff  <= pairv_ff;
         rspv_ff  <= sumv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pair_ff <= pair_in;
         sum_ff  <= sum_in;
         res_ff  <= res_in;
         clip_ff <= clip_in;
      end
   end

   assign rsp_valid   = rspv_ff;
   assign rsp_out_x   = $signed(res_ff[0]);
   assign rsp_out_y   = $signed(res_ff[1]);
   assign rsp_out_z   = $signed(res_ff[2]);
   assign rsp_out_w   = $signed(res_ff[3]);
   assign rsp_clipped = clip_ff;

endmodule

// ----- design/vertex_transform_4x4_top.sv -----
// Top level of the 4x4 vertex transform engine.
// Depends on vtx_pkg, vtx_front, vtx_back, vtx_reduce and the assertion header.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | mode, col/row index, element, x y z w
//   rsp     | out       | rsp_valid/rsp_ready  | out x y z w, clipped
//
// One transaction per cycle unless rsp stalls; a 4-entry queue sits between
// front and back. A transform reaches rsp after the queue through registers for
// products, pair sums, row sums and the saturated output.
// Writes give no response.
// Reset (synchronous) empties the queue and loads the identity matrix.
// A stalled rsp holds the back pipeline; the front keeps taking transactions
// until the queue fills.
module vertex_transform_4x4_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  logic [1:0]          req_col_index,
   input  logic [1:0]          req_row_index,
   input  logic signed [31:0]  req_element_value,
   input  logic signed [31:0]  req_vec_x,
   input  logic signed [31:0]  req_vec_y,
   input  logic signed [31:0]  req_vec_z,
   input  logic signed [31:0]  req_vec_w,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_out_x,
   output logic signed [31:0]  rsp_out_y,
   output logic signed [31:0]  rsp_out_z,
   output logic signed [31:0]  rsp_out_w,
   output logic                rsp_clipped
);
   import vtx_pkg::*;

   cmd_type                   head;
   qstat_type                 stat;
   logic                      deq;
   logic                      advance;
   logic                      prod_valid;
   logic signed [PROD_W-1:0]  prod [N_ELEM];
   logic                      any_sat;

   vtx_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_col_index     (req_col_index),
      .req_row_index     (req_row_index),
      .req_element_value (req_element_value),
      .req_vec_x         (req_vec_x),
      .req_vec_y         (req_vec_y),
      .req_vec_z         (req_vec_z),
      .req_vec_w         (req_vec_w),
      .deq               (deq),
      .head              (head),
      .stat              (stat)
   );

   vtx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .stat       (stat),
      .advance    (advance),
      .deq        (deq),
      .prod_valid (prod_valid),
      .prod       (prod)
   );

   vtx_reduce u_reduce (
      .clock       (clock),
      .reset       (reset),
      .prod_valid  (prod_valid),
      .prod        (prod),
      .rsp_ready   (rsp_ready),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_out_x   (rsp_out_x),
      .rsp_out_y   (rsp_out_y),
      .rsp_out_z   (rsp_out_z),
      .rsp_out_w   (rsp_out_w),
      .rsp_clipped (rsp_clipped)
   );

   // Flag a response component sitting at a saturation limit
   assign any_sat = (rsp_out_x == SAT_MAX) || (rsp_out_x == SAT_MIN) ||
                    (rsp_out_y == SAT_MAX) || (rsp_out_y == SAT_MIN) ||
                    (rsp_out_z == SAT_MAX) || (rsp_out_z == SAT_MIN) ||
                    (rsp_out_w == SAT_MAX) || (rsp_out_w == SAT_MIN);

   `include "vertex_transform_4x4_top_assert.svh"

   // Queue never overfills
   `VTX_ASSERT_NOW(a_fill_bound, 1'b1, stat.fill <= QCW'(QDEPTH), "queue fill above depth")
   // No transaction leaves the queue while the response is stalled
   `VTX_ASSERT_NOW(a_stall_no_deq, rsp_valid && !rsp_ready, !deq, "dequeue during stall")
   // Clipped response carries at least one saturated component
   `VTX_ASSERT_NOW(a_clip_extreme, rsp_valid && rsp_clipped, any_sat, "clipped, none saturated")
   // Queue is ready after a full queue drains one entry with no new transaction
   `VTX_ASSERT_NEXT(a_ready_after_deq, deq && !(req_valid && req_ready), req_ready, "not ready")

endmodule
